/* hdl/ssr_pkg.sv */
// Shared types and constants for the streaming string replace block.
// Used by every module under hdl; depends on nothing else.
package ssr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int JOB_DEPTH       = 4;
  localparam int JOB_PTR_W       = $clog2(JOB_DEPTH);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_index_t;

  // Configuration as the front end sees it, lengths already saturated.
  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_len;      // 1..8
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_len;  // 0..8
  } cfg_t;

  // One job: up to eight bytes to emit, in order from the lowest byte.
  typedef struct packed {
    logic [63:0] data;
    logic [2:0]  last_idx;
    logic        done;
  } job_t;

endpackage

/* hdl/ssr_front.sv */
// Front end: holds bytes that may begin a match and turns each text item into at most one job.
// Depends on ssr_pkg for cfg_t and job_t.
module ssr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  input  ssr_pkg::cfg_t cfg,
  output logic          job_push,
  output ssr_pkg::job_t job
);

  logic [2:0] held_count;
  logic [2:0] held_count_next;
  logic [7:0] held_bytes [8];
  logic [7:0] held_bytes_next [8];

  logic [7:0] buf_b [8];
  logic [3:0] n;
  logic [7:0] eq [8];
  logic [7:0] ok;
  logic       full_match;
  logic [3:0] sel;
  logic [3:0] cnt;
  logic [63:0] buf_word;

  assign n = {1'b0, held_count} + 4'd1;

  // Held bytes followed by the new byte.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < {1'b0, held_count}) begin
        buf_b[i] = held_bytes[i];
      end else if (4'(i) == {1'b0, held_count}) begin
        buf_b[i] = text_byte;
      end else begin
        buf_b[i] = 8'h00;
      end
      buf_word[8*i +: 8] = buf_b[i];
    end
  end

  // eq[s][i]: byte s+i of the buffer equals pattern byte i.
  always_comb begin
    for (int s = 0; s < 8; s++) begin
      for (int i = 0; i < 8; i++) begin
        if (s + i < 8) begin
          eq[s][i] = (buf_b[s+i] == cfg.pattern_bytes[8*i +: 8]);
        end else begin
          eq[s][i] = 1'b0;
        end
      end
    end
  end

  // ok[s]: the tail starting at s is a prefix of the pattern.
  always_comb begin
    logic [3:0] r;
    for (int s = 0; s < 8; s++) begin
      r = n - 4'(s);
      ok[s] = 1'b1;
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < r && !eq[s][i]) begin
          ok[s] = 1'b0;
        end
      end
    end
  end

  assign full_match = (n == cfg.pattern_len) && ok[0];

  // Shortest leading run to release so that the rest is a proper prefix.
  always_comb begin
    sel = n;
    for (int s = 7; s >= 0; s--) begin
      if (4'(s) < n && (n - 4'(s)) < cfg.pattern_len && ok[s]) begin
        sel = 4'(s);
      end
    end
  end

  always_comb begin
    logic [3:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = 4'(i) + sel;
      if (idx < 4'd8) begin
        held_bytes_next[i] = buf_b[idx[2:0]];
      end else begin
        held_bytes_next[i] = 8'h00;
      end
    end
    if (full_match || end_of_text) begin
      held_count_next = 3'd0;
    end else begin
      held_count_next = 3'(n - sel);
    end
  end

  // Job contents. An end of text that yields no character yields a marker.
  always_comb begin
    if (full_match) begin
      cnt      = cfg.replacement_len;
      job.data = cfg.replacement_bytes;
    end else begin
      cnt      = end_of_text ? n : sel;
      job.data = buf_word;
    end
    if (end_of_text && cnt == 4'd0) begin
      cnt      = 4'd1;
      job.data = 64'd0;
    end
    job.last_idx = 3'(cnt - 4'd1);
    job.done     = end_of_text;
    job_push     = accept && (cnt != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 3'd0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

/* hdl/ssr_job_fifo.sv */
// Short job queue between the front end and the output sequencer.
// Depends on ssr_pkg for job_t and the queue depth.
module ssr_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssr_pkg::job_t push_job,
  input  logic          pop,
  output ssr_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);

  ssr_pkg::job_t entries [ssr_pkg::JOB_DEPTH];
  logic [ssr_pkg::JOB_PTR_W-1:0] wr_ptr;
  logic [ssr_pkg::JOB_PTR_W-1:0] rd_ptr;
  logic [ssr_pkg::JOB_PTR_W:0]   count;

  assign full     = (count == (ssr_pkg::JOB_PTR_W+1)'(ssr_pkg::JOB_DEPTH));
  assign empty    = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + (ssr_pkg::JOB_PTR_W)'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + (ssr_pkg::JOB_PTR_W)'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (ssr_pkg::JOB_PTR_W+1)'(1);
        2'b01:   count <= count - (ssr_pkg::JOB_PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

/* hdl/ssr_back.sv */
// Output sequencer: takes jobs from the queue and presents their bytes one at a time, one per pop.
// Depends on ssr_pkg for job_t.
module ssr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  ssr_pkg::job_t job,
  output logic          job_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          text_done
);

  logic        active;
  logic [2:0]  idx;
  logic [63:0] data;
  logic [2:0]  last_idx;
  logic        done;
  logic        finish;

  assign finish  = active && pop && (idx == last_idx);
  assign job_pop = job_valid && (!active || finish);

  assign empty     = !active;
  assign out_byte  = data[{idx, 3'b000} +: 8];
  assign run_last  = (idx == last_idx);
  assign text_done = done && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 3'd0;
    end else if (job_pop) begin
      active <= 1'b1;
      idx    <= 3'd0;
    end else if (finish) begin
      active <= 1'b0;
    end else if (active && pop) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      data     <= job.data;
      last_idx <= job.last_idx;
      done     <= job.done;
    end
  end

endmodule

/* hdl/stream_string_replace_core.sv */
// Streaming find-and-replace top level: configuration registers, front end, job queue, output.
// Depends on ssr_pkg, ssr_front, ssr_job_fifo and ssr_back.
//
// Text bytes are pushed one per cycle while full is low; every leftmost, non-overlapping
// occurrence of the pattern is replaced, and bytes that may still begin a match are held
// back until they are resolved or the end of text flushes them. Each text item is
// classified in the cycle it is accepted and yields zero to eight results; full goes high
// only while the four-entry job queue is full. Results leave at one per cycle while pop
// is held high, so the sustained input rate is one item per cycle while each item yields
// at most one result, and otherwise is set by the output sequencer's one result per cycle.
// An accepted item's first result goes into the job queue, then the output sequencer's
// registers, before it is on the result ports. run_last marks the last result of an
// item, text_done the last result of the text. Write configuration only while idle.
module stream_string_replace_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        text_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;

  ssr_pkg::cfg_t cfg;
  ssr_pkg::job_t new_job;
  ssr_pkg::job_t head_job;
  logic          accept;
  logic          job_push;
  logic          job_pop;
  logic          job_empty;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= 64'd0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= 64'd0;
      replacement_length <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ssr_pkg::CFG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        ssr_pkg::CFG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        ssr_pkg::CFG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        ssr_pkg::CFG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Lengths outside the legal range saturate; a zero pattern length acts as one.
  always_comb begin
    cfg.pattern_bytes     = pattern_bytes;
    cfg.replacement_bytes = replacement_bytes;
    if (pattern_length == 4'd0) begin
      cfg.pattern_len = 4'd1;
    end else if (pattern_length > 4'(ssr_pkg::MAX_PATTERN)) begin
      cfg.pattern_len = 4'(ssr_pkg::MAX_PATTERN);
    end else begin
      cfg.pattern_len = pattern_length;
    end
    if (replacement_length > 4'(ssr_pkg::MAX_REPLACEMENT)) begin
      cfg.replacement_len = 4'(ssr_pkg::MAX_REPLACEMENT);
    end else begin
      cfg.replacement_len = replacement_length;
    end
  end

  ssr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .cfg         (cfg),
    .job_push    (job_push),
    .job         (new_job)
  );

  ssr_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (new_job),
    .pop      (job_pop),
    .head_job (head_job),
    .full     (full),
    .empty    (job_empty)
  );

  ssr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (head_job),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_done (text_done)
  );

`ifndef ASSERT_OFF
  // The front end only creates a job for an accepted item, so it never meets a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !job_push)
    else $error("job pushed into a full queue");

  // The end of text always produces at least one result.
  a_eot_has_job: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |-> job_push)
    else $error("end of text produced no job");

  // The final result of a text is also the last result of its item.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && text_done) |-> run_last)
    else $error("text_done without run_last");

  // A waiting job reaches the output on the next edge when the output is free.
  a_back_loads: assert property (@(posedge clk) disable iff (rst)
    (!job_empty && empty) |=> !empty)
    else $error("waiting job not loaded");
`endif

endmodule

/* sim/stream_string_replace_core_test.sv */
// Self-checking testbench for stream_string_replace_core: directed rows, then random texts.
// Depends on ssr_pkg and the block itself; results are checked against a predictor kept here.
`timescale 1ns / 1ps

module stream_string_replace_core_test;

  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int TEXT_ITEMS    = 420;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  mask;
    logic [63:0] pattern;
    logic [3:0]  plen;
    logic [63:0] repl;
    logic [3:0]  rlen;
    logic [7:0]  text;
    logic        eot;
    bit          typed;
    result_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        text_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  stream_string_replace_core u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .text_done   (text_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: registers as written, plus the bytes held back.
  logic [63:0] pat_word = 64'd0;
  logic [3:0]  pat_len_reg = 4'd1;
  logic [63:0] rep_word = 64'd0;
  logic [3:0]  rep_len_reg = 4'd0;
  logic [7:0]  held [8];
  int          held_n = 0;

  result_t     expected_q[$];
  result_t     oldest;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          pop_hold = 0;
  bit          pop_steady = 1'b0;
  bit          sender_steady = 1'b0;

  function automatic int eff_pat_len();
    if (pat_len_reg == 4'd0) return 1;
    if (pat_len_reg > 4'd8) return 8;
    return int'(pat_len_reg);
  endfunction

  function automatic bit is_prefix(input logic [7:0] window [8], input int off, input int len);
    for (int i = 0; i < len; i++) begin
      if (window[(off + i) & 7] != pat_word[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the results of one text byte, appends them to expected_q and returns how many.
  function automatic int predict_item(input logic [7:0] b, input logic eot);
    logic [7:0] window [8];
    result_t    res[$];
    int         n;
    int         s;
    int         plen;
    int         rlen;
    n = (held_n > 7) ? 7 : held_n;
    for (int i = 0; i < 8; i++) window[i] = (i < n) ? held[i] : 8'h00;
    window[n] = b;
    n++;
    plen = eff_pat_len();
    rlen = (rep_len_reg > 4'd8) ? 8 : int'(rep_len_reg);
    if (n == plen && is_prefix(window, 0, plen)) begin
      for (int i = 0; i < rlen; i++) res.push_back('{rep_word[8*i +: 8], 1'b0, 1'b0});
      held_n = 0;
    end else begin
      // Release the shortest leading run that leaves a proper prefix of the pattern.
      for (s = 0; s < n; s++) begin
        if (n - s < plen && is_prefix(window, s, n - s)) break;
      end
      for (int i = 0; i < s; i++) res.push_back('{window[i], 1'b0, 1'b0});
      held_n = n - s;
      for (int i = 0; i < n - s; i++) held[i] = window[s + i];
    end
    if (eot) begin
      for (int i = 0; i < held_n; i++) res.push_back('{held[i], 1'b0, 1'b0});
      held_n = 0;
      if (res.size() == 0) res.push_back('{8'h00, 1'b0, 1'b0});
      res[res.size() - 1].text_done = 1'b1;
    end
    if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
    foreach (res[i]) expected_q.push_back(res[i]);
    return res.size();
  endfunction

  function automatic logic [7:0] alpha_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'h61;
    if (r < 80) return 8'h62;
    if (r < 90) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 49) == 0) sender_steady = !sender_steady;
    if (sender_steady || $urandom_range(0, 99) < 55) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // An item that produced nothing may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] b, input logic eot, output int produced);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    do @(posedge clk); while (full);
    produced = predict_item(b, eot);
  endtask

  task automatic write_config(input logic [3:0] mask, input logic [63:0] pattern,
                              input logic [3:0] plen, input logic [63:0] repl,
                              input logic [3:0] rlen);
    ssr_pkg::cfg_index_t idx;
    logic [63:0]         value;
    wait_idle();
    for (int k = 0; k < 4; k++) begin
      if (mask[k]) begin
        idx = ssr_pkg::cfg_index_t'(k);
        case (idx)
          ssr_pkg::CFG_PATTERN_BYTES:      value = pattern;
          ssr_pkg::CFG_PATTERN_LENGTH:     value = {60'd0, plen};
          ssr_pkg::CFG_REPLACEMENT_BYTES:  value = repl;
          ssr_pkg::CFG_REPLACEMENT_LENGTH: value = {60'd0, rlen};
          default:                         value = 64'd0;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
          ssr_pkg::CFG_PATTERN_BYTES:      pat_word = value;
          ssr_pkg::CFG_PATTERN_LENGTH:     pat_len_reg = value[3:0];
          ssr_pkg::CFG_REPLACEMENT_BYTES:  rep_word = value;
          ssr_pkg::CFG_REPLACEMENT_LENGTH: rep_len_reg = value[3:0];
          default: ;
        endcase
      end
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic row_t item_row(input logic [7:0] b, input logic eot);
    row_t r;
    r = '{ROW_ITEM, 4'd0, 64'd0, 4'd0, 64'd0, 4'd0, b, eot, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t typed_row(input logic [7:0] b, input logic eot, input result_t want);
    row_t r;
    r = '{ROW_ITEM, 4'd0, 64'd0, 4'd0, 64'd0, 4'd0, b, eot, 1'b1, want};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [3:0] mask, input logic [63:0] pattern,
                                   input logic [3:0] plen, input logic [63:0] repl,
                                   input logic [3:0] rlen);
    row_t r;
    r = '{ROW_CFG, mask, pattern, plen, repl, rlen, 8'h00, 1'b0, 1'b0, '0};
    return r;
  endfunction

  // Output side: check each accepted result and stall pop at random.
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: out_byte %02h run_last %0b text_done %0b",
                 out_byte, run_last, text_done);
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          if (out_byte !== oldest.out_byte) begin
            $error("out_byte: expected %02h, got %02h", oldest.out_byte, out_byte);
            mismatches++;
          end
          if (run_last !== oldest.run_last) begin
            $error("run_last: expected %0b, got %0b", oldest.run_last, run_last);
            mismatches++;
          end
          if (text_done !== oldest.text_done) begin
            $error("text_done: expected %0b, got %0b", oldest.text_done, text_done);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) pop_steady <= !pop_steady;
      if (pop_hold > 0) begin
        pop      <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else begin
        pop <= 1'b1;
        if (!pop_steady && $urandom_range(0, 99) < 20) begin
          pop_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stream_string_replace_core test failed");
      $finish;
    end
  end

  initial begin
    row_t        plan[$];
    logic [7:0]  text_q[$];
    logic [63:0] pattern;
    logic [63:0] repl;
    logic [3:0]  mask;
    logic [3:0]  raw_plen;
    logic [3:0]  raw_rlen;
    int          produced;
    int          sent;
    int          phase;
    int          phase_items;
    int          target;
    int          eff_plen;
    int          cut;
    int          r;
    int          tlen;
    bit          carry;

    // Right after reset the pattern is a single zero byte and the replacement is empty.
    plan.push_back(typed_row(8'h41, 1'b0, '{8'h41, 1'b1, 1'b0}));
    plan.push_back(item_row(8'h00, 1'b0));
    plan.push_back(typed_row(8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1}));
    // A deleted final byte leaves only the end-of-text marker.
    plan.push_back(typed_row(8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}));
    // "abc" -> "XY" over "xababcz": a failed partial match is released and rescanned.
    plan.push_back(cfg_row(4'hF, 64'h636261, 4'd3, 64'h5958, 4'd2));
    plan.push_back(item_row(8'h78, 1'b0));
    plan.push_back(item_row(8'h61, 1'b0));
    plan.push_back(item_row(8'h62, 1'b0));
    plan.push_back(item_row(8'h61, 1'b0));
    plan.push_back(item_row(8'h62, 1'b0));
    plan.push_back(item_row(8'h63, 1'b0));
    plan.push_back(item_row(8'h7A, 1'b1));
    // Longest pattern and longest replacement.
    plan.push_back(cfg_row(4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,
                           64'h8040_2010_0804_0201, 4'd8));
    for (int i = 0; i < 7; i++) plan.push_back(item_row(8'hFF, 1'b0));
    plan.push_back(item_row(8'hFF, 1'b1));
    // Pattern length zero acts as one; replacement length fifteen saturates at eight.
    plan.push_back(cfg_row(4'b1010, 64'd0, 4'd0, 64'd0, 4'd15));
    plan.push_back(item_row(8'hFF, 1'b0));
    plan.push_back(item_row(8'h7F, 1'b1));
    // Pattern rewritten while bytes are held back.
    plan.push_back(cfg_row(4'b0011, 64'h626161, 4'd3, 64'd0, 4'd0));
    plan.push_back(item_row(8'h61, 1'b0));
    plan.push_back(item_row(8'h61, 1'b0));
    plan.push_back(cfg_row(4'b0011, 64'h6261, 4'd2, 64'd0, 4'd0));
    plan.push_back(item_row(8'h62, 1'b1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_config(plan[i].mask, plan[i].pattern, plan[i].plen, plan[i].repl, plan[i].rlen);
      end else begin
        send_item(plan[i].text, plan[i].eot, produced);
        if (plan[i].typed) begin
          repeat (produced) void'(expected_q.pop_back());
          expected_q.push_back(plan[i].want);
        end
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < TEXT_ITEMS) begin
      case (phase % 4)
        0: begin
          eff_plen = 8;
          raw_plen = $urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(9, 15));
          raw_rlen = $urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(9, 15));
        end
        1: begin
          eff_plen = 1;
          raw_plen = 4'($urandom_range(0, 1));
          raw_rlen = 4'd0;
        end
        default: begin
          eff_plen = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
          raw_plen = 4'(eff_plen);
          raw_rlen = 4'($urandom_range(0, 8));
        end
      endcase
      pattern = {$urandom, $urandom};
      for (int i = 0; i < eff_plen; i++) pattern[8*i +: 8] = alpha_byte();
      repl = {$urandom, $urandom};
      mask = (phase < 2 || $urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom_range(1, 15));
      write_config(mask, pattern, raw_plen, repl, raw_rlen);

      // Texts are built mostly from copies and prefixes of the pattern now in force.
      eff_plen    = eff_pat_len();
      target      = $urandom_range(20, 60);
      phase_items = 0;
      while (phase_items < target) begin
        text_q.delete();
        tlen = $urandom_range(1, 16);
        while (text_q.size() < tlen) begin
          r = $urandom_range(0, 99);
          if (r < 35) begin
            for (int i = 0; i < eff_plen; i++) text_q.push_back(pat_word[8*i +: 8]);
          end else if (r < 55) begin
            cut = (eff_plen > 1) ? $urandom_range(1, eff_plen - 1) : 1;
            for (int i = 0; i < cut; i++) text_q.push_back(pat_word[8*i +: 8]);
          end else if (r < 85) begin
            text_q.push_back(alpha_byte());
          end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        // Now and then the last text of a phase is left open across the next write.
        carry = (phase_items + text_q.size() >= target) && ($urandom_range(0, 3) == 0);
        foreach (text_q[k]) begin
          if ($urandom_range(0, 59) == 0) wait_idle();
          send_item(text_q[k], (k == text_q.size() - 1) && !carry, produced);
        end
        phase_items += text_q.size();
      end
      sent += phase_items;
      phase++;
    end

    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("stream_string_replace_core test passed");
    end else begin
      $display("stream_string_replace_core test failed");
    end
    $finish;
  end

endmodule
